FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`endif

FILE: rtl/ddpa_pkg.sv
// ----------------------------------------------------------------------------
// ddpa_pkg
// Types, constants and helper functions of the dot product accumulator.
// ----------------------------------------------------------------------------
package ddpa_pkg;

   localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
   localparam logic [10:0] EXP_ONES  = 11'h7FF;
   localparam logic [12:0] EXP_BIAS  = 13'd1023;

   typedef enum logic [1:0] {
      OP_NOP,
      OP_MAC,
      OP_MISMATCH
   } op_kind_type;

   // One queued item after classification.
   typedef struct packed {
      op_kind_type kind;
      logic        final_item;
      logic [63:0] first_bits;
      logic [63:0] second_bits;
   } op_type;

   // Control that travels alongside the product through the multiplier.
   typedef struct packed {
      op_kind_type kind;
      logic        final_item;
   } ctl_type;

   // Leading zero count of a 64-bit word; an all-zero word gives 64.
   function automatic logic [6:0] lzc64(input logic [63:0] v);
      logic [63:0] t;
      logic [6:0]  n;
      t = v;
      n = 7'd0;
      if (t[63:32] == 32'd0) begin n = n + 7'd32; t = t << 32; end
      if (t[63:48] == 16'd0) begin n = n + 7'd16; t = t << 16; end
      if (t[63:56] == 8'd0)  begin n = n + 7'd8;  t = t << 8;  end
      if (t[63:60] == 4'd0)  begin n = n + 7'd4;  t = t << 4;  end
      if (t[63:62] == 2'd0)  begin n = n + 7'd2;  t = t << 2;  end
      if (t[63] == 1'b0)     begin n = n + 7'd1;  t = t << 1;  end
      if (t[63] == 1'b0)     begin n = n + 7'd1;                end
      return n;
   endfunction

endpackage

FILE: rtl/ddpa_if.sv
// ----------------------------------------------------------------------------
// ddpa_if
// Valid/ready channels of the dot product accumulator.
// ----------------------------------------------------------------------------
interface ddpa_req_if;
   logic        valid;
   logic        ready;
   logic        first_present;
   logic        second_present;
   logic [63:0] first_bits;
   logic [63:0] second_bits;
   logic        final_item;

   modport source (output valid, output first_present, output second_present,
                   output first_bits, output second_bits, output final_item,
                   input ready);
   modport sink (input valid, input first_present, input second_present,
                 input first_bits, input second_bits, input final_item,
                 output ready);
endinterface

interface ddpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] dot_bits;
   logic        size_mismatch;

   modport source (output valid, output dot_bits, output size_mismatch, input ready);
   modport sink (input valid, input dot_bits, input size_mismatch, output ready);
endinterface

FILE: rtl/double_dot_product_accumulator.sv
// ----------------------------------------------------------------------------
// double_dot_product_accumulator
// Streaming binary64 dot product with a sticky length mismatch flag.
//
// Each item with both elements present is multiplied in a five-stage pipeline
// and then added to the running sum, both rounded to nearest even and never
// fused. For an item with both elements, the running sum passes through the
// six steps of the adder (operand ordering, alignment, add, leading-zero
// count, normalization, rounding) and into the sum register before the next
// pair can start, so the accumulator takes no new pair while one is in the
// adder. The final item loads the result register. A queue of QUEUE_DEPTH
// items in front of the multiplier keeps the input side accepting while the
// accumulator works, and the result register lets the next vector start
// while a result waits to be taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module double_dot_product_accumulator #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   ddpa_req_if.sink   req_ch,
   ddpa_rsp_if.source rsp_ch
);
   import ddpa_pkg::*;

   logic   q_valid;
   logic   q_pop;
   op_type q_data;

   ddpa_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (q_valid),
      .q_data  (q_data),
      .q_pop   (q_pop)
   );

   ddpa_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (q_data),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

   `ASSERT_IMPLIES(a_pop_needs_item, clock, reset, q_pop, q_valid)
   `ASSERT_IMPLIES(a_mismatch_zero, clock, reset, rsp_ch.valid && rsp_ch.size_mismatch, rsp_ch.dot_bits == 64'd0)
   `ASSERT_ALWAYS(a_nan_canonical, clock, reset, !(rsp_ch.valid && (rsp_ch.dot_bits[62:52] == EXP_ONES) && (rsp_ch.dot_bits[51:0] != 52'd0)) || (rsp_ch.dot_bits == CANON_NAN))

endmodule

FILE: rtl/ddpa_front.sv
// ----------------------------------------------------------------------------
// ddpa_front
// Accepts items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module ddpa_front #(
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   ddpa_req_if.sink         req_ch,
   output logic             q_valid,
   output ddpa_pkg::op_type q_data,
   input  logic             q_pop
);
   import ddpa_pkg::*;

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   op_type          mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            accept, push;
   op_kind_type     kind;
   op_type          entry;

   assign req_ch.ready = (cnt_ff != CW'(DEPTH));
   assign accept       = req_ch.valid && req_ch.ready;
   assign q_valid      = (cnt_ff != '0);
   assign q_data       = mem_ff[rd_ff];

   always_comb begin
      if (req_ch.first_present && req_ch.second_present) begin
         kind = OP_MAC;
      end else if (req_ch.first_present != req_ch.second_present) begin
         kind = OP_MISMATCH;
      end else begin
         kind = OP_NOP;
      end
      entry.kind        = kind;
      entry.final_item  = req_ch.final_item;
      entry.first_bits  = req_ch.first_bits;
      entry.second_bits = req_ch.second_bits;
      // An item with no element and no end mark leaves no trace.
      push = accept && ((kind != OP_NOP) || req_ch.final_item);

      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      case ({push, q_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= entry;
      end
   end

endmodule

FILE: rtl/ddpa_fmul.sv
// ----------------------------------------------------------------------------
// ddpa_fmul
// Five-stage binary64 multiplier with round to nearest even.
// ----------------------------------------------------------------------------
module ddpa_fmul (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ddpa_pkg::op_type  in_op,
   output logic              in_take,
   output logic              out_valid,
   output ddpa_pkg::ctl_type out_ctl,
   output logic [63:0]       out_prod,
   input  logic              out_take
);
   import ddpa_pkg::*;

   typedef struct packed {
      logic sign;
      logic nan;
      logic inf;
      logic zero;
   } flags_type;

   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   ctl_type c1_ff, c2_ff, c3_ff, c4_ff, c5_ff;
   flags_type f1_ff, f2_ff, f3_ff, f4_ff;

   // Stage 1: unpack and normalize subnormal operands.
   logic        sa, sb;
   logic [10:0] ea, eb;
   logic [51:0] fa, fb;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [52:0] ma, mb;
   logic [6:0]  lza, lzb;
   flags_type   f1_in;
   logic [52:0] na1_in, nb1_in, na1_ff, nb1_ff;
   logic signed [12:0] xa1_in, xb1_in, xa1_ff, xb1_ff;

   // Stage 2: partial products.
   logic [53:0] hh2_in, hh2_ff;
   logic [52:0] hl2_in, hl2_ff, lh2_in, lh2_ff;
   logic [51:0] ll2_in, ll2_ff;
   logic signed [12:0] e2_in, e2_ff;

   // Stage 3: full product.
   logic [53:0]  mid3;
   logic [105:0] prod3_in, prod3_ff;
   logic signed [12:0] e3_ff;

   // Stage 4: normalize and align subnormal results.
   logic         top4;
   logic [105:0] n4;
   logic signed [12:0] e4, one_minus4;
   logic [54:0]  w4, sft4;
   logic [5:0]   sh4;
   logic         lost4;
   logic [54:0]  q4_in, q4_ff;
   logic [10:0]  fld4_in, fld4_ff;
   logic         ovf4_in, ovf4_ff;

   // Stage 5: round and pack.
   logic [52:0] mant5;
   logic        up5;
   logic [62:0] packed5;
   logic [63:0] prod5_in, prod5_ff;

   assign adv       = !v5_ff || out_take;
   assign in_take   = adv && in_valid;
   assign out_valid = v5_ff;
   assign out_ctl   = c5_ff;
   assign out_prod  = prod5_ff;

   always_comb begin
      {sa, ea, fa} = in_op.first_bits;
      {sb, eb, fb} = in_op.second_bits;
      a_nan  = (ea == EXP_ONES) && (fa != 52'd0);
      b_nan  = (eb == EXP_ONES) && (fb != 52'd0);
      a_inf  = (ea == EXP_ONES) && (fa == 52'd0);
      b_inf  = (eb == EXP_ONES) && (fb == 52'd0);
      a_zero = (ea == 11'd0) && (fa == 52'd0);
      b_zero = (eb == 11'd0) && (fb == 52'd0);
      f1_in.sign = sa ^ sb;
      f1_in.nan  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
      f1_in.inf  = (a_inf || b_inf) && !f1_in.nan;
      f1_in.zero = (a_zero || b_zero) && !f1_in.nan && !f1_in.inf;
      ma = {ea != 11'd0, fa};
      mb = {eb != 11'd0, fb};
      lza = lzc64({ma, 11'd0});
      lzb = lzc64({mb, 11'd0});
      na1_in = ma << lza[5:0];
      nb1_in = mb << lzb[5:0];
      xa1_in = $signed({2'b00, (ea == 11'd0) ? 11'd1 : ea}) - $signed({6'd0, lza});
      xb1_in = $signed({2'b00, (eb == 11'd0) ? 11'd1 : eb}) - $signed({6'd0, lzb});
   end

   always_comb begin
      hh2_in = {27'd0, na1_ff[52:26]} * {27'd0, nb1_ff[52:26]};
      hl2_in = {26'd0, na1_ff[52:26]} * {27'd0, nb1_ff[25:0]};
      lh2_in = {27'd0, na1_ff[25:0]} * {26'd0, nb1_ff[52:26]};
      ll2_in = {26'd0, na1_ff[25:0]} * {26'd0, nb1_ff[25:0]};
      e2_in  = xa1_ff + xb1_ff - $signed(EXP_BIAS);
   end

   always_comb begin
      mid3     = {1'b0, hl2_ff} + {1'b0, lh2_ff};
      prod3_in = {hh2_ff, 52'd0} + {26'd0, mid3, 26'd0} + {54'd0, ll2_ff};
   end

   always_comb begin
      top4 = prod3_ff[105];
      n4   = top4 ? prod3_ff : {prod3_ff[104:0], 1'b0};
      e4   = e3_ff + $signed({12'd0, top4});
      w4   = {n4[105:52], |n4[51:0]};
      one_minus4 = 13'sd1 - e4;
      if (e4 > 13'sd0) begin
         sh4 = 6'd0;
      end else if (e4 < -13'sd54) begin
         sh4 = 6'd56;
      end else begin
         sh4 = one_minus4[5:0];
      end
      sft4    = w4 >> sh4;
      lost4   = |(w4 & ~({55{1'b1}} << sh4));
      q4_in   = {sft4[54:1], sft4[0] | lost4};
      fld4_in = (e4 > 13'sd0) ? e4[10:0] : 11'd0;
      ovf4_in = (e4 > 13'sd2046);
   end

   always_comb begin
      mant5   = q4_ff[54:2];
      up5     = q4_ff[1] && (q4_ff[0] || mant5[0]);
      packed5 = {fld4_ff, mant5[51:0]} + {62'd0, up5};
      if (f4_ff.nan) begin
         prod5_in = CANON_NAN;
      end else if (f4_ff.inf) begin
         prod5_in = {f4_ff.sign, EXP_ONES, 52'd0};
      end else if (f4_ff.zero) begin
         prod5_in = {f4_ff.sign, 63'd0};
      end else if (ovf4_ff) begin
         prod5_in = {f4_ff.sign, EXP_ONES, 52'd0};
      end else begin
         prod5_in = {f4_ff.sign, packed5};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_ff    <= '{kind: in_op.kind, final_item: in_op.final_item};
         f1_ff    <= f1_in;
         na1_ff   <= na1_in;
         nb1_ff   <= nb1_in;
         xa1_ff   <= xa1_in;
         xb1_ff   <= xb1_in;
         c2_ff    <= c1_ff;
         f2_ff    <= f1_ff;
         hh2_ff   <= hh2_in;
         hl2_ff   <= hl2_in;
         lh2_ff   <= lh2_in;
         ll2_ff   <= ll2_in;
         e2_ff    <= e2_in;
         c3_ff    <= c2_ff;
         f3_ff    <= f2_ff;
         prod3_ff <= prod3_in;
         e3_ff    <= e2_ff;
         c4_ff    <= c3_ff;
         f4_ff    <= f3_ff;
         q4_ff    <= q4_in;
         fld4_ff  <= fld4_in;
         ovf4_ff  <= ovf4_in;
         c5_ff    <= c4_ff;
         prod5_ff <= prod5_in;
      end
   end

endmodule

FILE: rtl/ddpa_fadd.sv
// ----------------------------------------------------------------------------
// ddpa_fadd
// Multi-cycle binary64 adder with round to nearest even.
// ----------------------------------------------------------------------------
module ddpa_fadd (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] x,
   input  logic [63:0] y,
   output logic        done,
   output logic [63:0] result
);
   import ddpa_pkg::*;

   typedef enum logic [2:0] {
      F_IDLE,
      F_ALIGN,
      F_ADD,
      F_LZC,
      F_NORM,
      F_ROUND
   } fstate_type;

   fstate_type  state_ff, state_in;
   logic        done_ff, done_in;
   logic [63:0] res_ff, res_in;

   logic        sign_ff, sign_in, sub_ff, sub_in, zsign_ff, zsign_in;
   logic        spec_ff, spec_in, zero_ff, zero_in;
   logic [63:0] specres_ff, specres_in;
   logic [10:0] eb_ff, eb_in, d_ff, d_in;
   logic [55:0] mb_ff, mb_in, al_ff, al_in;
   logic [56:0] s_ff, s_in;
   logic [6:0]  sh_ff, sh_in;
   logic [55:0] n_ff, n_in;
   logic [11:0] e_ff, e_in;

   logic        sx, sy, x_nan, y_nan, x_inf, y_inf, x_ge;
   logic [63:0] big, small_op;
   logic [10:0] eb_eff, es_eff, lim;
   logic [6:0]  lz;
   logic [52:0] mant;
   logic        up;
   logic [10:0] fld;
   logic [62:0] packed_res;

   assign done   = done_ff;
   assign result = res_ff;

   always_comb begin
      sx    = x[63];
      sy    = y[63];
      x_nan = (x[62:52] == EXP_ONES) && (x[51:0] != 52'd0);
      y_nan = (y[62:52] == EXP_ONES) && (y[51:0] != 52'd0);
      x_inf = (x[62:52] == EXP_ONES) && (x[51:0] == 52'd0);
      y_inf = (y[62:52] == EXP_ONES) && (y[51:0] == 52'd0);
      x_ge  = (x[62:0] >= y[62:0]);
      big      = x_ge ? x : y;
      small_op = x_ge ? y : x;
      eb_eff = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
      es_eff = (small_op[62:52] == 11'd0) ? 11'd1 : small_op[62:52];
      lz  = lzc64({s_ff[55:0], 8'd0});
      lim = eb_ff - 11'd1;
      mant = n_ff[55:3];
      up   = n_ff[2] && ((|n_ff[1:0]) || mant[0]);
      fld  = n_ff[55] ? e_ff[10:0] : 11'd0;
      packed_res = {fld, mant[51:0]} + {62'd0, up};

      state_in   = state_ff;
      done_in    = 1'b0;
      res_in     = res_ff;
      sign_in    = sign_ff;
      sub_in     = sub_ff;
      zsign_in   = zsign_ff;
      spec_in    = spec_ff;
      specres_in = specres_ff;
      zero_in    = zero_ff;
      eb_in      = eb_ff;
      d_in       = d_ff;
      mb_in      = mb_ff;
      al_in      = al_ff;
      s_in       = s_ff;
      sh_in      = sh_ff;
      n_in       = n_ff;
      e_in       = e_ff;

      unique case (state_ff)
         F_IDLE: begin
            if (start) begin
               // Order the operands by magnitude so the difference is never negative.
               sign_in  = big[63];
               sub_in   = sx ^ sy;
               zsign_in = sx && sy;
               spec_in  = x_nan || y_nan || x_inf || y_inf;
               if (x_nan || y_nan || (x_inf && y_inf && (sx != sy))) begin
                  specres_in = CANON_NAN;
               end else if (x_inf) begin
                  specres_in = x;
               end else begin
                  specres_in = y;
               end
               eb_in    = eb_eff;
               d_in     = eb_eff - es_eff;
               mb_in    = {big[62:52] != 11'd0, big[51:0], 3'b000};
               al_in    = {small_op[62:52] != 11'd0, small_op[51:0], 3'b000};
               state_in = F_ALIGN;
            end
         end
         F_ALIGN: begin
            if (d_ff > 11'd55) begin
               al_in = {55'd0, |al_ff};
            end else begin
               al_in = al_ff >> d_ff[5:0];
               al_in[0] = al_in[0] | (|(al_ff & ~({56{1'b1}} << d_ff[5:0])));
            end
            state_in = F_ADD;
         end
         F_ADD: begin
            s_in = sub_ff ? ({1'b0, mb_ff} - {1'b0, al_ff}) : ({1'b0, mb_ff} + {1'b0, al_ff});
            state_in = F_LZC;
         end
         F_LZC: begin
            // The left shift stops where the exponent would drop below the
            // subnormal range.
            sh_in    = ({4'd0, lz} < lim) ? lz : lim[6:0];
            zero_in  = (s_ff == 57'd0);
            state_in = F_NORM;
         end
         F_NORM: begin
            if (s_ff[56]) begin
               n_in = {s_ff[56:2], s_ff[1] | s_ff[0]};
               e_in = {1'b0, eb_ff} + 12'd1;
            end else begin
               n_in = s_ff[55:0] << sh_ff;
               e_in = {1'b0, eb_ff} - {5'd0, sh_ff};
            end
            state_in = F_ROUND;
         end
         F_ROUND: begin
            if (spec_ff) begin
               res_in = specres_ff;
            end else if (zero_ff) begin
               res_in = {zsign_ff, 63'd0};
            end else if (e_ff == {1'b0, EXP_ONES}) begin
               res_in = {sign_ff, EXP_ONES, 52'd0};
            end else begin
               res_in = {sign_ff, packed_res};
            end
            done_in  = 1'b1;
            state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      res_ff     <= res_in;
      sign_ff    <= sign_in;
      sub_ff     <= sub_in;
      zsign_ff   <= zsign_in;
      spec_ff    <= spec_in;
      specres_ff <= specres_in;
      zero_ff    <= zero_in;
      eb_ff      <= eb_in;
      d_ff       <= d_in;
      mb_ff      <= mb_in;
      al_ff      <= al_in;
      s_ff       <= s_in;
      sh_ff      <= sh_in;
      n_ff       <= n_in;
      e_ff       <= e_in;
   end

endmodule

FILE: rtl/ddpa_back.sv
// ----------------------------------------------------------------------------
// ddpa_back
// Multiplies queued pairs, accumulates them and delivers the result item.
// ----------------------------------------------------------------------------
module ddpa_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  ddpa_pkg::op_type q_data,
   output logic             q_pop,
   ddpa_rsp_if.source       rsp_ch
);
   import ddpa_pkg::*;

   typedef enum logic [1:0] {
      B_IDLE,
      B_ADD,
      B_EMIT
   } bstate_type;

   bstate_type  state_ff, state_in;
   logic [63:0] sum_ff, sum_in;
   logic        mis_ff, mis_in;
   logic        fin_ff, fin_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_dot_ff, rsp_dot_in;
   logic        rsp_mis_ff, rsp_mis_in;

   logic        mul_valid, take, add_start, add_done;
   ctl_type     mul_ctl;
   logic [63:0] mul_prod, add_result;

   function automatic logic [63:0] canon(input logic [63:0] b);
      if ((b[62:52] == EXP_ONES) && (b[51:0] != 52'd0)) begin
         return CANON_NAN;
      end
      return b;
   endfunction

   ddpa_fmul u_fmul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_op     (q_data),
      .in_take   (q_pop),
      .out_valid (mul_valid),
      .out_ctl   (mul_ctl),
      .out_prod  (mul_prod),
      .out_take  (take)
   );

   ddpa_fadd u_fadd (
      .clock  (clock),
      .reset  (reset),
      .start  (add_start),
      .x      (sum_ff),
      .y      (mul_prod),
      .done   (add_done),
      .result (add_result)
   );

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.dot_bits      = rsp_dot_ff;
   assign rsp_ch.size_mismatch = rsp_mis_ff;

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      mis_in       = mis_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_dot_in   = rsp_dot_ff;
      rsp_mis_in   = rsp_mis_ff;
      take         = 1'b0;
      add_start    = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (mul_valid) begin
               take   = 1'b1;
               fin_in = mul_ctl.final_item;
               if (mul_ctl.kind == OP_MAC) begin
                  add_start = 1'b1;
                  state_in  = B_ADD;
               end else begin
                  if (mul_ctl.kind == OP_MISMATCH) begin
                     mis_in = 1'b1;
                  end
                  if (mul_ctl.final_item) begin
                     state_in = B_EMIT;
                  end
               end
            end
         end
         B_ADD: begin
            if (add_done) begin
               sum_in   = add_result;
               state_in = fin_ff ? B_EMIT : B_IDLE;
            end
         end
         B_EMIT: begin
            // The result register frees up in the same cycle it is taken.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_dot_in   = mis_ff ? 64'd0 : canon(sum_ff);
               rsp_mis_in   = mis_ff;
               sum_in       = 64'd0;
               mis_in       = 1'b0;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         sum_ff       <= 64'd0;
         mis_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         mis_ff       <= mis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fin_ff     <= fin_in;
      rsp_dot_ff <= rsp_dot_in;
      rsp_mis_ff <= rsp_mis_in;
   end

endmodule

FILE: bench/double_dot_product_accumulator_tb.sv
// ----------------------------------------------------------------------------
// double_dot_product_accumulator_tb
// Streams binary64 vector pairs through the dot product accumulator and
// checks every sum and length flag against a predictor built on real
// arithmetic, or against results typed into the directed table, under
// random bursts on the request side and stalls on the response side.
// ----------------------------------------------------------------------------
module double_dot_product_accumulator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ddpa_pkg::*;

   localparam logic [63:0] POS_ZERO = 64'h0000_0000_0000_0000;
   localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ONE      = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] TWO      = 64'h4000_0000_0000_0000;
   localparam logic [63:0] THREE    = 64'h4008_0000_0000_0000;
   localparam logic [63:0] SEVEN    = 64'h401C_0000_0000_0000;
   localparam logic [63:0] HALF     = 64'h3FE0_0000_0000_0000;
   localparam logic [63:0] POS_INF  = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] NEG_INF  = 64'hFFF0_0000_0000_0000;
   localparam logic [63:0] MAX_FIN  = 64'h7FEF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MIN_NORM = 64'h0010_0000_0000_0000;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int TOTAL_ITEMS = 400;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      bit          first_present;
      bit          second_present;
      logic [63:0] first_bits;
      logic [63:0] second_bits;
      bit          final_item;
      bit          known;          // expected result typed into the table
      logic [63:0] known_dot;
      bit          known_mismatch;
      bit          pause_first;    // wait for all results before this item
      bit          hold_first;     // start the long receiver hold-off here
   } vec_item_type;

   typedef struct {
      logic [63:0] dot_bits;
      bit          size_mismatch;
   } dot_result_type;

   logic clock;
   logic reset;

   ddpa_req_if req_if ();
   ddpa_rsp_if rsp_if ();

   double_dot_product_accumulator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   vec_item_type   stim_q[$];
   vec_item_type   offered_q[$];
   dot_result_type expected_dots[$];
   logic [63:0]    sum_bits;
   bit             length_differs;
   int             mismatch_count;
   bit             hold_request;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Product and sum each go through a real, so each is rounded on its own.
   function automatic dot_result_type accumulate_pair(input vec_item_type it,
                                                      output bit emits);
      dot_result_type r;
      real            prod;
      if (it.first_present && it.second_present) begin
         prod = $bitstoreal(it.first_bits) * $bitstoreal(it.second_bits);
         sum_bits = $realtobits($bitstoreal(sum_bits) + prod);
      end else if (it.first_present != it.second_present) begin
         length_differs = 1'b1;
      end
      emits = it.final_item;
      r.size_mismatch = length_differs;
      if (length_differs)
         r.dot_bits = POS_ZERO;
      else if (sum_bits[62:52] == EXP_ONES && sum_bits[51:0] != 52'd0)
         r.dot_bits = CANON_NAN;
      else
         r.dot_bits = sum_bits;
      if (it.final_item) begin
         sum_bits = POS_ZERO;
         length_differs = 1'b0;
      end
      return r;
   endfunction

   function automatic void add_row(input bit fp, input bit sp, input logic [63:0] a,
                                   input logic [63:0] b, input bit fin, input bit known,
                                   input logic [63:0] dot, input bit mm);
      vec_item_type it;
      it = '{fp, sp, a, b, fin, known, dot, mm, 1'b0, 1'b0};
      stim_q.push_back(it);
   endfunction

   function automatic logic [63:0] random_double();
      logic [63:0] v;
      case ($urandom_range(0, 9))
         0, 1: v = {$urandom, $urandom};
         2: begin
            case ($urandom_range(0, 7))
               0: v = POS_ZERO;
               1: v = NEG_ZERO;
               2: v = POS_INF;
               3: v = NEG_INF;
               4: v = MAX_FIN;
               5: v = MIN_NORM;
               6: v = {32'd0, $urandom};
               default: v = {1'b0, EXP_ONES, 4'($urandom_range(1, 15)), 48'd0};
            endcase
         end
         default: begin
            v = {$urandom, $urandom};
            v[62:52] = 11'd1023 + 11'($urandom_range(0, 40)) - 11'd20;
         end
      endcase
      return v;
   endfunction

   // Directed table followed by random vectors.
   task automatic build_stimulus();
      int vec_len;
      vec_item_type it;
      add_row(0, 0, ALL_ONES, ALL_ONES, 1, 1, POS_ZERO, 0);
      add_row(1, 1, ONE, ONE, 0, 0, POS_ZERO, 0);
      add_row(1, 1, TWO, THREE, 1, 1, SEVEN, 0);
      add_row(1, 0, ONE, ALL_ONES, 1, 1, POS_ZERO, 1);
      add_row(0, 1, ALL_ONES, TWO, 0, 0, POS_ZERO, 0);
      add_row(1, 1, TWO, TWO, 1, 1, POS_ZERO, 1);
      add_row(0, 0, ONE, ONE, 0, 0, POS_ZERO, 0);
      add_row(0, 0, POS_ZERO, POS_ZERO, 1, 1, POS_ZERO, 0);
      add_row(1, 1, MAX_FIN, MAX_FIN, 1, 1, POS_INF, 0);
      add_row(1, 1, POS_INF, POS_ZERO, 1, 1, CANON_NAN, 0);
      add_row(1, 1, 64'hFFF0_0000_0000_0001, ONE, 1, 1, CANON_NAN, 0);
      add_row(1, 1, NEG_ZERO, POS_ZERO, 1, 1, POS_ZERO, 0);
      add_row(1, 1, 64'h1, HALF, 0, 0, POS_ZERO, 0);
      add_row(1, 1, 64'h3, HALF, 1, 1, 64'h2, 0);
      add_row(1, 1, POS_INF, ONE, 0, 0, POS_ZERO, 0);
      add_row(1, 1, NEG_INF, ONE, 1, 1, CANON_NAN, 0);
      add_row(1, 1, ALL_ONES, ALL_ONES, 1, 1, CANON_NAN, 0);
      add_row(1, 1, 64'h3FF1_9999_9999_999A, 64'h400A_6666_6666_6666, 0, 0, POS_ZERO, 0);
      add_row(1, 1, 64'hBFB9_9999_9999_999A, 64'h3FD5_5555_5555_5555, 1, 0, POS_ZERO, 0);
      add_row(1, 1, MIN_NORM, 64'h3CB0_0000_0000_0000, 1, 0, POS_ZERO, 0);
      while (stim_q.size() < TOTAL_ITEMS) begin
         vec_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
         for (int k = 0; k <= vec_len; k++) begin
            it.first_bits = random_double();
            it.second_bits = random_double();
            it.final_item = (k == vec_len);
            it.known = 1'b0;
            it.known_dot = POS_ZERO;
            it.known_mismatch = 1'b0;
            it.pause_first = 1'b0;
            it.hold_first = 1'b0;
            case ($urandom_range(0, 19))
               0: begin it.first_present = 1; it.second_present = 0; end
               1: begin it.first_present = 0; it.second_present = 1; end
               2: begin it.first_present = 0; it.second_present = 0; end
               default: begin
                  it.first_present = (k != vec_len);
                  it.second_present = (k != vec_len);
               end
            endcase
            if (k == 0 && stim_q.size() >= 100 && stim_q.size() < 110)
               it.hold_first = 1'b1;
            if (k == 0 && stim_q.size() >= 250 && stim_q.size() < 260)
               it.pause_first = 1'b1;
            stim_q.push_back(it);
         end
      end
   endtask

   task automatic wait_for_results();
      while (expected_dots.size() != 0 || offered_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Request side: bursts of items with random gaps between them.
   initial begin
      int burst_left;
      bit held;
      vec_item_type it;
      req_if.valid <= 1'b0;
      req_if.first_present <= 1'b0;
      req_if.second_present <= 1'b0;
      req_if.first_bits <= '0;
      req_if.second_bits <= '0;
      req_if.final_item <= 1'b0;
      reset <= 1'b1;
      hold_request = 1'b0;
      sum_bits = POS_ZERO;
      length_differs = 1'b0;
      mismatch_count = 0;
      held = 1'b0;
      build_stimulus();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      burst_left = 0;
      while (stim_q.size() != 0) begin
         it = stim_q.pop_front();
         if (it.pause_first) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
            wait_for_results();
         end
         if (it.hold_first && !held) begin
            hold_request = 1'b1;
            held = 1'b1;
            burst_left = 200;
         end
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
            if ($urandom_range(0, 1)) begin
               req_if.valid <= 1'b0;
               repeat ($urandom_range(1, 15)) @(posedge clock);
            end
         end
         burst_left--;
         offered_q.push_back(it);
         req_if.valid <= 1'b1;
         req_if.first_present <= it.first_present;
         req_if.second_present <= it.second_present;
         req_if.first_bits <= it.first_bits;
         req_if.second_bits <= it.second_bits;
         req_if.final_item <= it.final_item;
         do @(posedge clock); while (!req_if.ready);
      end
      req_if.valid <= 1'b0;
      wait_for_results();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Response side: changing stall patterns, plus one long hold-off.
   initial begin
      int stall_mode;
      rsp_if.ready <= 1'b0;
      stall_mode = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         if ($urandom_range(0, 31) == 0)
            stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= $urandom_range(0, 1);
            default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Each accepted item updates the running prediction.
   always @(posedge clock) begin
      vec_item_type it;
      dot_result_type r;
      bit emits;
      if (!reset && req_if.valid && req_if.ready) begin
         it = offered_q.pop_front();
         r = accumulate_pair(it, emits);
         if (emits) begin
            if (it.known) begin
               r.dot_bits = it.known_dot;
               r.size_mismatch = it.known_mismatch;
            end
            expected_dots.push_back(r);
         end
      end
   end

   always @(posedge clock) begin
      dot_result_type r;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_dots.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result dot=%h mismatch=%b",
                        rsp_if.dot_bits, rsp_if.size_mismatch);
         end else begin
            r = expected_dots.pop_front();
            if (rsp_if.dot_bits !== r.dot_bits || rsp_if.size_mismatch !== r.size_mismatch) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result differs: expected dot=%h mismatch=%b, got dot=%h mismatch=%b",
                           r.dot_bits, r.size_mismatch, rsp_if.dot_bits,
                           rsp_if.size_mismatch);
            end
         end
      end
   end

   // Worst case is far below this: about 400 items through the accumulator plus stalls.
   initial begin
      #6ms;
      $display("Mismatches found");
      $finish;
   end

endmodule
